@@ sv/btoi_pkg.sv @@
`default_nettype none

package btoi_pkg;

    // Fixed field widths
    localparam int CH_W      = 8;
    localparam int VALUE_W   = 32;
    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int ALPH_W    = 2 * CFG_W;

    // Largest alphabet the register file can hold
    localparam int MAX_DIGITS_DEF = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH   = 2'd2;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_DEL   = 8'd127;

    // Lookup result for one character against the alphabet
    typedef struct packed {
        logic               alphabet_ok;
        logic               hit;
        logic [LEN_W-2:0]   index;
    } btoi_match_t;

endpackage

`default_nettype wire

@@ sv/btoi_alphabet.sv @@
`default_nettype none

module btoi_alphabet
    import btoi_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic [LEN_W-1:0]  length,
    input  wire logic [ALPH_W-1:0] chars,
    input  wire logic [CH_W-1:0]   ch,
    output btoi_match_t            result
);

    logic [MAX_DIGITS-1:0] in_use;
    logic [MAX_DIGITS-1:0] bad_char;
    logic [MAX_DIGITS-1:0] dup;
    logic [MAX_DIGITS-1:0] eq;
    logic [CH_W-1:0]       entry [MAX_DIGITS];
    logic                  len_ok;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            entry[i]    = chars[CH_W*i +: CH_W];
            in_use[i]   = (LEN_W'(i) < length);
            bad_char[i] = (entry[i] <= CH_SPACE) || (entry[i] >= CH_DEL)
                          || (entry[i] == CH_PLUS) || (entry[i] == CH_MINUS);
            eq[i]       = in_use[i] && (entry[i] == ch);
        end
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            dup[i] = 1'b0;
            for (int j = i + 1; j < MAX_DIGITS; j++)
            begin
                if (in_use[j] && (entry[j] == entry[i]))
                begin
                    dup[i] = 1'b1;
                end
            end
        end
    end

    assign len_ok = (length >= LEN_W'(2)) && (length <= LEN_W'(MAX_DIGITS));

    // Lowest matching index wins
    always_comb
    begin
        result.alphabet_ok = len_ok && ((in_use & (bad_char | dup)) == '0);
        result.hit         = |eq;
        result.index       = '0;
        for (int i = MAX_DIGITS - 1; i >= 0; i--)
        begin
            if (eq[i])
            begin
                result.index = (LEN_W-1)'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/base_n_text_to_integer.sv @@
`default_nettype none

// Text-to-integer converter with a programmable digit alphabet. Feed one text
// byte per transaction on ch; a zero byte ends the string and produces exactly
// one transaction on value, the parsed signed 32-bit integer (wrapped modulo
// 2^32, or 0 on a malformed string or an invalid alphabet). Leading whitespace
// (bytes 9 to 13 and 32) is skipped, then a run of '+'/'-' sets the sign (each
// '-' flips it), then each byte must match alphabet entry k and updates the
// accumulator to acc * length + k. Any other byte in the digit part poisons
// the string until its terminator. The alphabet is programmed through the
// configuration port: index 0 is the length (data bits 4:0), index 1 holds
// characters 0..7 and index 2 characters 8..15, one byte each, character k at
// bits 8k+7:8k. It is valid only with 2..MAX_DIGITS distinct printable
// characters other than '+' and '-'. Program it only while no string is in
// flight. The block sustains one byte per clock unless held off: a byte is
// registered in ch_reg, then parsed by the alphabet compare plus a 32x5
// multiply-add that closes the state loop, so a result passes through the
// input register and then the output register before it is valid. The
// result sits in that output register; input is held off only when a
// terminator is ready to parse while that register is still full and
// stalled.
module base_n_text_to_integer
    import btoi_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [CH_W-1:0]           ch,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [VALUE_W-1:0]      value,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGIT,
        PH_ERROR
    } phase_t;

    // Configuration registers
    logic [LEN_W-1:0]   alphabet_length_reg;
    logic [CFG_W-1:0]   alphabet_low_reg;
    logic [CFG_W-1:0]   alphabet_high_reg;

    // Input register
    logic               ch_valid_reg;
    logic [CH_W-1:0]    ch_reg;

    // Parse state
    phase_t             phase_reg, phase_next;
    logic               negative_reg, negative_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    logic               out_free;
    logic               fire;
    logic               take_in;
    btoi_match_t        match;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_length_reg <= '0;
            alphabet_low_reg    <= '0;
            alphabet_high_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ALPHABET_LENGTH: alphabet_length_reg <= cfg_data[LEN_W-1:0];
                REG_ALPHABET_LOW:    alphabet_low_reg    <= cfg_data;
                REG_ALPHABET_HIGH:   alphabet_high_reg   <= cfg_data;
                default:             ;  // unmapped index: drop the write
            endcase
        end
    end

    btoi_alphabet #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_alphabet (
        .length (alphabet_length_reg),
        .chars  ({alphabet_high_reg, alphabet_low_reg}),
        .ch     (ch_reg),
        .result (match)
    );

    // A terminator may only be parsed when the output slot frees up this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = ch_valid_reg && ((ch_reg != CH_NUL) || out_free);
    assign take_in  = !ch_valid_reg || fire;
    assign in_stall = !take_in;

    always_comb
    begin
        phase_t p;
        logic   used;
        p              = phase_reg;
        used           = 1'b0;
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        acc_next       = acc_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (fire)
        begin
            if (ch_reg == CH_NUL)
            begin
                // Emit result and start over
                if ((phase_reg != PH_ERROR) && match.alphabet_ok)
                begin
                    value_next = negative_reg ? (VALUE_W'(0) - acc_reg) : acc_reg;
                end
                else
                begin
                    value_next = '0;
                end
                out_valid_next = 1'b1;
                phase_next     = PH_SKIP;
                negative_next  = 1'b0;
                acc_next       = '0;
            end
            else
            begin
                if (p == PH_SKIP)
                begin
                    if (((ch_reg >= CH_TAB) && (ch_reg <= CH_CR)) || (ch_reg == CH_SPACE))
                    begin
                        used = 1'b1;
                    end
                    else
                    begin
                        p = PH_SIGN;
                    end
                end
                if (!used && (p == PH_SIGN))
                begin
                    if ((ch_reg == CH_PLUS) || (ch_reg == CH_MINUS))
                    begin
                        used = 1'b1;
                        if (ch_reg == CH_MINUS)
                        begin
                            negative_next = !negative_reg;
                        end
                    end
                    else
                    begin
                        p = PH_DIGIT;
                    end
                end
                if (!used && (p == PH_DIGIT))
                begin
                    if (match.hit)
                    begin
                        acc_next = VALUE_W'(acc_reg * VALUE_W'(alphabet_length_reg))
                                   + VALUE_W'(match.index);
                    end
                    else
                    begin
                        p = PH_ERROR;
                    end
                end
                phase_next = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid_reg  <= 1'b0;
            phase_reg     <= PH_SKIP;
            negative_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                ch_valid_reg <= in_valid;
            end
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take_in && in_valid)
        begin
            ch_reg <= ch;
        end
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire
